// ===== design/crc_codeword_checker_top_defines.svh =====
// Assertion helpers shared by the checker modules.
// Each expects clk and rst (active high) in scope.
`ifndef CRC_CODEWORD_CHECKER_TOP_DEFINES_SVH
`define CRC_CODEWORD_CHECKER_TOP_DEFINES_SVH

// Same-cycle implication.
`define CCC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CCC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ccc_pkg.sv =====
`default_nettype none
package ccc_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_GEN_BITS  = 2'd0;
  localparam logic [1:0] REG_GEN_LEN   = 2'd1;
  localparam logic [1:0] REG_DW_EIGHT  = 2'd2;

  // register reset values
  localparam logic [8:0] GEN_BITS_RST  = 9'd11;
  localparam logic [3:0] GEN_LEN_RST   = 4'd4;
  localparam logic       DW_EIGHT_RST  = 1'b0;

  // result kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_SUM  = 1'b1;

  // front-to-back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] FULL_BYTE_BITS = 4'd8;

  typedef struct packed {
    logic [8:0] gen_bits;
    logic [3:0] gen_len;
    logic       dw_eight;
  } ccc_cfg_t;

  // all results caused by one input byte
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data_byte;
    logic        has_tail;
    logic [7:0]  tail_byte;
    logic [3:0]  tail_bits;
    logic        has_sum;
    logic [31:0] codeword_total;
    logic [31:0] error_total;
  } ccc_entry_t;

endpackage
`default_nettype wire

// ===== design/crc_codeword_checker_top.sv =====
// Channel  | Dir | Signals                         | Contents
// s        | in  | s_tvalid/s_tready/s_tdata/tlast | coded byte, last byte of stream
// m        | out | m_tvalid/m_tready/m_tdata/tuser | result, kind, last result of byte
// apb      | cfg | psel/penable/pwrite/paddr/...   | generator bits, length, dataword
//
// One input byte per cycle while the queue is not full: all eight division steps
// of a byte run in the front in the cycle the byte is taken. Results leave the back
// at one per cycle while m_tready is high; a byte's k results (0 to 3) hold its
// queue slot until the last is taken. A two-entry queue between front and back
// lets input and output stall independently. Reset is synchronous and active high;
// it loads register defaults and clears the stream state, as does each last byte.
`default_nettype none
module crc_codeword_checker_top #(
  parameter int MAX_GEN_LEN = 9,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // stream in, tdata: in_byte[7:0]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  // stream out, tdata: data_byte[7:0], data_bits[11:8], codeword_total[43:12],
  // error_total[75:44], zero[79:76]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,
  // tuser: kind[0]
  output logic             m_tuser,
  output logic             m_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import ccc_pkg::*;

  ccc_cfg_t   cfg;
  ccc_entry_t push_entry, head;
  logic       push, pop, q_valid, q_full;

  ccc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ccc_front #(
    .MAX_GEN_LEN (MAX_GEN_LEN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ccc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .valid      (q_valid),
    .full       (q_full)
  );

  ccc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_valid  (q_valid),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== design/ccc_regs.sv =====
`default_nettype none
module ccc_regs (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output ccc_pkg::ccc_cfg_t      cfg
);
  import ccc_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gen_bits <= GEN_BITS_RST;
      cfg.gen_len  <= GEN_LEN_RST;
      cfg.dw_eight <= DW_EIGHT_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_GEN_BITS: cfg.gen_bits <= pwdata[8:0];
        REG_GEN_LEN:  cfg.gen_len  <= pwdata[3:0];
        REG_DW_EIGHT: cfg.dw_eight <= pwdata[0];
        default: ;
      endcase
    end
  end

  // return the addressed register
  always_comb begin
    case (paddr[3:2])
      REG_GEN_BITS: prdata = {23'd0, cfg.gen_bits};
      REG_GEN_LEN:  prdata = {28'd0, cfg.gen_len};
      REG_DW_EIGHT: prdata = {31'd0, cfg.dw_eight};
      default:      prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ccc_front.sv =====
`default_nettype none
`include "crc_codeword_checker_top_defines.svh"
module ccc_front #(
  parameter int MAX_GEN_LEN = 9,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ccc_pkg::ccc_cfg_t  cfg,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,
  input  wire logic               s_tlast,
  input  wire logic               q_full,
  output logic                    push,
  output ccc_pkg::ccc_entry_t     push_entry
);
  import ccc_pkg::*;

  localparam int GW  = (MAX_GEN_LEN > 9) ? MAX_GEN_LEN : 9;
  localparam int RW  = MAX_GEN_LEN - 1;
  localparam int PW  = $clog2(8 + MAX_GEN_LEN);
  localparam int GLW = ($clog2(MAX_GEN_LEN + 1) > 4) ? $clog2(MAX_GEN_LEN + 1) : 4;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // stream state
  logic                   header_done, header_done_next;
  logic [7:0]             padding_left, padding_left_next;
  logic [PW-1:0]          codeword_bit_pos, codeword_bit_pos_next;
  logic [RW-1:0]          remainder_reg, remainder_reg_next;
  logic [7:0]             data_hold, data_hold_next;
  logic [7:0]             out_accum, out_accum_next;
  logic [3:0]             out_fill, out_fill_next;
  logic [COUNT_WIDTH-1:0] codeword_count, codeword_count_next;
  logic [COUNT_WIDTH-1:0] error_count, error_count_next;

  logic                   accept;
  logic [GLW-1:0]         len_w, g;
  logic [3:0]             dw;
  logic [PW-1:0]          cw;
  logic [GW-1:0]          gen_wide, lead_mask;
  logic [RW-1:0]          rmask;
  logic [1:0]             n_cw, n_err;
  logic                   emit;
  logic [7:0]             emit_byte;
  logic [COUNT_WIDTH:0]   cw_sum, err_sum;

  assign s_tready = !q_full;
  assign accept   = s_tvalid & s_tready;

  // effective generator length and codeword size
  always_comb begin
    len_w = GLW'(cfg.gen_len);
    if (len_w < GLW'(2))
      g = GLW'(2);
    else if (len_w > GLW'(MAX_GEN_LEN))
      g = GLW'(MAX_GEN_LEN);
    else
      g = len_w;
    dw        = cfg.dw_eight ? 4'd8 : 4'd4;
    cw        = PW'(dw) + PW'(g) - PW'(1);
    gen_wide  = GW'(cfg.gen_bits);
    lead_mask = GW'(1) << (g - GLW'(1));
    rmask     = RW'(lead_mask - GW'(1));
  end

  // run the eight bit steps of one byte
  always_comb begin
    logic [GW-1:0] rfull;
    logic [7:0]    pad;
    logic [PW-1:0] pos;
    logic [RW-1:0] rem;
    logic [7:0]    hold;
    logic [7:0]    acc;
    logic [3:0]    fill;
    pad       = padding_left;
    pos       = codeword_bit_pos;
    rem       = remainder_reg;
    hold      = data_hold;
    acc       = out_accum;
    fill      = out_fill;
    n_cw      = 2'd0;
    n_err     = 2'd0;
    emit      = 1'b0;
    emit_byte = 8'd0;
    rfull     = '0;
    for (int i = 7; i >= 0; i--) begin
      if (pad != 8'd0) begin
        pad = pad - 8'd1;
      end else begin
        if (pos < PW'(dw))
          hold = {hold[6:0], s_tdata[i]};
        rfull = (GW'(rem) << 1) | GW'(s_tdata[i]);
        if ((rfull & lead_mask) != '0)
          rfull = rfull ^ gen_wide;
        rem = RW'(rfull) & rmask;
        pos = pos + PW'(1);
        if (pos >= cw) begin
          n_cw = n_cw + 2'd1;
          if (rem != '0)
            n_err = n_err + 2'd1;
          // pack the dataword; fill is always zero or one nibble
          if (cfg.dw_eight) begin
            emit = 1'b1;
            if (fill == 4'd0) begin
              emit_byte = hold;
              acc       = 8'd0;
            end else begin
              emit_byte = {acc[3:0], hold[7:4]};
              acc       = {4'd0, hold[3:0]};
            end
          end else begin
            if (fill == 4'd0) begin
              acc  = {4'd0, hold[3:0]};
              fill = 4'd4;
            end else begin
              emit      = 1'b1;
              emit_byte = {acc[3:0], hold[3:0]};
              acc       = 8'd0;
              fill      = 4'd0;
            end
          end
          pos  = '0;
          rem  = '0;
          hold = 8'd0;
        end
      end
    end

    cw_sum  = {1'b0, codeword_count} + (COUNT_WIDTH+1)'(n_cw);
    err_sum = {1'b0, error_count} + (COUNT_WIDTH+1)'(n_err);

    header_done_next      = header_done;
    padding_left_next     = padding_left;
    codeword_bit_pos_next = codeword_bit_pos;
    remainder_reg_next    = remainder_reg;
    data_hold_next        = data_hold;
    out_accum_next        = out_accum;
    out_fill_next         = out_fill;
    codeword_count_next   = codeword_count;
    error_count_next      = error_count;

    if (!header_done) begin
      header_done_next  = 1'b1;
      padding_left_next = s_tdata;
    end else begin
      padding_left_next     = pad;
      codeword_bit_pos_next = pos;
      remainder_reg_next    = rem;
      data_hold_next        = hold;
      out_accum_next        = acc;
      out_fill_next         = fill;
      codeword_count_next   = cw_sum[COUNT_WIDTH] ? COUNT_MAX : cw_sum[COUNT_WIDTH-1:0];
      error_count_next      = err_sum[COUNT_WIDTH] ? COUNT_MAX : err_sum[COUNT_WIDTH-1:0];
    end
  end

  // build the queue entry for this byte
  always_comb begin
    push_entry.has_data       = header_done & emit;
    push_entry.data_byte      = emit_byte;
    push_entry.has_tail       = s_tlast & (out_fill_next != 4'd0);
    push_entry.tail_byte      = out_accum_next;
    push_entry.tail_bits      = out_fill_next;
    push_entry.has_sum        = s_tlast;
    push_entry.codeword_total = 32'(codeword_count_next);
    push_entry.error_total    = 32'(error_count_next);
    push = accept & (push_entry.has_data | s_tlast);
  end

  // advance the stream state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      header_done      <= 1'b0;
      padding_left     <= 8'd0;
      codeword_bit_pos <= '0;
      remainder_reg    <= '0;
      data_hold        <= 8'd0;
      out_accum        <= 8'd0;
      out_fill         <= 4'd0;
      codeword_count   <= '0;
      error_count      <= '0;
    end else if (accept) begin
      header_done      <= header_done_next;
      padding_left     <= padding_left_next;
      codeword_bit_pos <= codeword_bit_pos_next;
      remainder_reg    <= remainder_reg_next;
      data_hold        <= data_hold_next;
      out_accum        <= out_accum_next;
      out_fill         <= out_fill_next;
      codeword_count   <= codeword_count_next;
      error_count      <= error_count_next;
    end
  end

  `CCC_CHECK(a_fill_nibble, 1'b1, out_fill == 4'd0 || out_fill == 4'd4, "out_fill off nibble")
  `CCC_CHECK_NEXT(a_restart, accept && s_tlast, !header_done && out_fill == 4'd0, "no restart")

endmodule
`default_nettype wire

// ===== design/ccc_queue.sv =====
`default_nettype none
`include "crc_codeword_checker_top_defines.svh"
module ccc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ccc_pkg::ccc_entry_t  push_entry,
  input  wire logic                 pop,
  output ccc_pkg::ccc_entry_t       head,
  output logic                      valid,
  output logic                      full
);
  import ccc_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ccc_entry_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign valid = count != '0;
  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign head  = slots[rd_ptr];

  // store pushed entries
  always_ff @(posedge clk) begin
    if (push)
      slots[wr_ptr] <= push_entry;
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      if (push && !pop)
        count <= count + CNT_W'(1);
      else if (pop && !push)
        count <= count - CNT_W'(1);
    end
  end

  `CCC_CHECK(a_no_overflow, push, !full, "push into full queue")
  `CCC_CHECK(a_no_underflow, pop, valid, "pop from empty queue")

endmodule
`default_nettype wire

// ===== design/ccc_back.sv =====
`default_nettype none
`include "crc_codeword_checker_top_defines.svh"
module ccc_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ccc_pkg::ccc_entry_t  head,
  input  wire logic                 q_valid,
  output logic                      pop,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [79:0]               m_tdata,
  output logic                      m_tuser,
  output logic                      m_tlast
);
  import ccc_pkg::*;

  logic       done_data, done_tail;
  logic       sel_data, sel_tail, sel_sum;
  logic       xfer;
  logic [7:0] out_byte;
  logic [3:0] out_bits;

  // pick the next result of the head entry
  always_comb begin
    sel_data = head.has_data & !done_data;
    sel_tail = !sel_data & head.has_tail & !done_tail;
    sel_sum  = !sel_data & !sel_tail;
    if (sel_data) begin
      out_byte = head.data_byte;
      out_bits = FULL_BYTE_BITS;
      m_tlast  = !(head.has_tail | head.has_sum);
    end else if (sel_tail) begin
      out_byte = head.tail_byte;
      out_bits = head.tail_bits;
      m_tlast  = !head.has_sum;
    end else begin
      out_byte = 8'd0;
      out_bits = 4'd0;
      m_tlast  = 1'b1;
    end
  end

  assign m_tvalid = q_valid;
  assign m_tuser  = sel_sum ? KIND_SUM : KIND_DATA;
  assign m_tdata  = {4'd0,
                     sel_sum ? head.error_total : 32'd0,
                     sel_sum ? head.codeword_total : 32'd0,
                     out_bits, out_byte};
  assign xfer     = m_tvalid & m_tready;
  assign pop      = xfer & m_tlast;

  // mark delivered results; drop the entry after its last one
  always_ff @(posedge clk) begin
    if (rst || pop) begin
      done_data <= 1'b0;
      done_tail <= 1'b0;
    end else if (xfer) begin
      if (sel_data)
        done_data <= 1'b1;
      if (sel_tail)
        done_tail <= 1'b1;
    end
  end

  `CCC_CHECK(a_sum_last, m_tvalid && m_tuser == KIND_SUM, m_tlast, "summary not last")
  `CCC_CHECK_NEXT(a_entry_held, xfer && !m_tlast, m_tvalid, "entry lost mid-run")

endmodule
`default_nettype wire
